// ===== design/nls_pkg.sv =====
// Shared types and constants for the numeric literal scanner.
package nls_pkg;

    // Character codes used by the classifier.
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;

    // Configuration register indexes and reset values.
    localparam logic CFG_FORMAT_MODE     = 1'b0;
    localparam logic CFG_BUFFER_CAPACITY = 1'b1;
    localparam logic [4:0]  FORMAT_MODE_RST     = 5'd1;
    localparam logic [12:0] BUFFER_CAPACITY_RST = 13'd64;

    // Format mode bit positions.
    localparam int FM_FLOAT = 0;
    localparam int FM_HEX_X = 1;
    localparam int FM_HEX_H = 2;
    localparam int FM_BIN   = 3;
    localparam int FM_SIGN  = 4;

    localparam int MAX_TOKEN_LEN_DEF = 4096;
    localparam logic [11:0] LEN_MAX = 12'hFFF;

    typedef struct packed {
        logic is_dec;
        logic is_zero;
        logic is_one;
        logic is_hex;
        logic is_dot;
        logic is_e;
        logic is_x;
        logic is_h;
        logic is_b;
        logic is_sign;
    } nls_class_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       token_start;
        logic       end_of_data;
        nls_class_t cls;
    } nls_entry_t;

endpackage

// ===== design/numeric_literal_scanner.sv =====
// Numeric literal scanner: top level joining classifier, queue and scanner core.
//
// The block takes one character per input beat on the s_ channel and returns
// exactly one result beat on the m_ channel for each. A beat with token_start
// set begins a new literal with its byte; a beat with end_of_data set carries
// no byte and closes the current literal. Each accepted byte comes back with
// its store index when it fits the buffer capacity; the first rejected byte,
// or end of data, closes the literal and reports its length and truncation,
// with m_tlast marking that closing beat. A rejected byte is dropped and not counted.
// Beats that arrive while no literal is open give an all-zero result.
// An input beat passes the two-entry queue after the classifier and then the
// result register of the core. The throughput is one beat per clock while the
// receiver is ready. When the receiver stalls, the queue fills and s_tready
// drops after two more beats; nothing is lost. Configuration writes are taken
// every cycle (cfg_ready is tied high) and must only be issued while the block
// is idle. Reset empties the queue and the result register, closes any literal
// and restores format_mode to 1 (float only) and buffer_capacity to 64.
module numeric_literal_scanner #(
    parameter int MAX_TOKEN_LEN = nls_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_tuser,   // [0] token_start, [1] end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] store_enable, [13:2] store_index, [21:14] store_byte,
    // [33:22] token_length, [34] truncated, [39:35] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,   // token_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index, // 0 format_mode, 1 buffer_capacity
    input  logic [12:0] cfg_data
);
    import nls_pkg::*;

    logic       push_valid, push_ready;
    nls_entry_t push_data;
    logic       pop_valid, pop_ready;
    nls_entry_t pop_data;

    // The classifier decodes the character class of each byte; it holds no state.
    nls_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // The queue lets the input side keep flowing for two beats of output stall.
    nls_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The core runs the literal state machine and registers one result per beat.
    nls_back #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/nls_front.sv =====
// Front end: takes input beats and classifies each byte for the scanner core.
module nls_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              push_valid,
    input  logic              push_ready,
    output nls_pkg::nls_entry_t push_data
);
    import nls_pkg::*;

    logic [7:0] c;
    nls_class_t cls;

    assign c = s_tdata;

    always_comb
    begin
        cls.is_dec  = (c >= CH_ZERO) && (c <= CH_NINE);
        cls.is_zero = (c == CH_ZERO);
        cls.is_one  = (c == CH_ONE);
        cls.is_hex  = cls.is_dec || ((c >= CH_LO_A) && (c <= CH_LO_F))
                      || ((c >= CH_UP_A) && (c <= CH_UP_F));
        cls.is_dot  = (c == CH_DOT);
        cls.is_e    = (c == CH_LO_E) || (c == CH_UP_E);
        cls.is_x    = (c == CH_LO_X) || (c == CH_UP_X);
        cls.is_h    = (c == CH_LO_H) || (c == CH_UP_H);
        cls.is_b    = (c == CH_LO_B) || (c == CH_UP_B);
        cls.is_sign = (c == CH_PLUS) || (c == CH_MINUS);
    end

    assign push_valid            = s_tvalid;
    assign s_tready              = push_ready;
    assign push_data.in_byte     = c;
    assign push_data.token_start = s_tuser[0];
    assign push_data.end_of_data = s_tuser[1];
    assign push_data.cls         = cls;

endmodule

// ===== design/nls_fifo.sv =====
// Two-entry queue between the classifier and the scanner core.
module nls_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  nls_pkg::nls_entry_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output nls_pkg::nls_entry_t pop_data
);
    import nls_pkg::*;

    nls_entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/nls_back.sv =====
// Scanner core: literal state machine, configuration registers and result register.
module nls_back #(
    parameter int MAX_TOKEN_LEN = nls_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  nls_pkg::nls_entry_t pop_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [12:0]         cfg_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic                m_tlast
);
    import nls_pkg::*;

    localparam logic [2:0] PH_INT   = 3'd0;
    localparam logic [2:0] PH_FRAC  = 3'd2;
    localparam logic [2:0] PH_ESIGN = 3'd4;
    localparam logic [2:0] PH_EDIG  = 3'd5;
    localparam logic [2:0] PH_HEX   = 3'd6;
    localparam logic [2:0] PH_BIN   = 3'd7;

    localparam int CAP_LIM_I = (MAX_TOKEN_LEN > 8191) ? 8191 : MAX_TOKEN_LEN;
    localparam logic [12:0] CAP_LIM = CAP_LIM_I[12:0];

    logic [4:0]  format_mode_reg;
    logic [12:0] capacity_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [11:0] count_reg, count_next;
    logic        lone_zero_reg, lone_zero_next;
    logic        active_reg, active_next;
    logic        ovf_reg, ovf_next;

    logic        out_valid_reg;
    logic [39:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic        take;
    logic [12:0] cap_eff;
    logic [2:0]  ph;
    logic [11:0] cnt;
    logic        lz, ovf, act, accept, first;
    nls_class_t  k;
    logic        flt;
    logic        store_en, trunc;

    assign cfg_ready = 1'b1;
    assign pop_ready = !out_valid_reg || m_tready;
    assign take      = pop_valid && pop_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    always_comb
    begin
        if (capacity_reg == 13'd0)
        begin
            cap_eff = 13'd1;
        end
        else if (capacity_reg > CAP_LIM)
        begin
            cap_eff = CAP_LIM;
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    always_comb
    begin
        k     = pop_data.cls;
        flt   = format_mode_reg[FM_FLOAT];
        ph    = pop_data.token_start ? PH_INT : phase_reg;
        cnt   = pop_data.token_start ? 12'd0 : count_reg;
        lz    = pop_data.token_start ? 1'b0 : lone_zero_reg;
        ovf   = pop_data.token_start ? 1'b0 : ovf_reg;
        act   = pop_data.token_start || active_reg;
        first = (cnt == 12'd0) && !ovf;

        phase_next     = ph;
        lone_zero_next = lz;
        accept         = 1'b0;

        // Exponent sign: an optional sign, otherwise judge as exponent digit.
        if (ph == PH_ESIGN)
        begin
            phase_next = PH_EDIG;
        end
        if (ph == PH_ESIGN && k.is_sign)
        begin
            accept = 1'b1;
        end
        else if (ph == PH_INT || ph == PH_FRAC || ph == PH_EDIG || ph == PH_ESIGN)
        begin
            if (k.is_dec)
            begin
                accept = 1'b1;
                if (first)
                begin
                    lone_zero_next = k.is_zero;
                end
            end
            else if (ph == PH_INT && k.is_dot && flt)
            begin
                accept     = 1'b1;
                phase_next = PH_FRAC;
            end
            else if ((ph == PH_INT || ph == PH_FRAC) && k.is_e && flt)
            begin
                accept     = 1'b1;
                phase_next = PH_ESIGN;
            end
            else if (ph == PH_INT && lz && cnt == 12'd1 && !ovf
                     && ((format_mode_reg[FM_HEX_H] && k.is_h)
                         || (format_mode_reg[FM_HEX_X] && k.is_x)))
            begin
                accept     = 1'b1;
                phase_next = PH_HEX;
            end
            else if (ph == PH_INT && lz && cnt == 12'd1 && !ovf
                     && format_mode_reg[FM_BIN] && k.is_b)
            begin
                accept     = 1'b1;
                phase_next = PH_BIN;
            end
            else if (format_mode_reg[FM_SIGN] && first && k.is_sign)
            begin
                accept = 1'b1;
            end
        end
        else if (ph == PH_HEX)
        begin
            accept = k.is_hex;
        end
        else if (ph == PH_BIN)
        begin
            accept = k.is_zero || k.is_one;
        end

        accept   = accept && !pop_data.end_of_data;
        store_en = !ovf && ({1'b0, cnt} < cap_eff);
        trunc    = ovf || ({1'b0, cnt} >= cap_eff);

        count_next    = cnt;
        ovf_next      = ovf;
        active_next   = act;
        out_data_next = 40'd0;
        out_last_next = 1'b0;

        if (!act)
        begin
            phase_next     = phase_reg;
            lone_zero_next = lone_zero_reg;
            count_next     = count_reg;
            ovf_next       = ovf_reg;
        end
        else if (accept)
        begin
            out_data_next[0] = 1'b1;
            if (store_en)
            begin
                out_data_next[1]     = 1'b1;
                out_data_next[13:2]  = cnt;
                out_data_next[21:14] = pop_data.in_byte;
            end
            if (cnt < LEN_MAX)
            begin
                count_next = cnt + 12'd1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else
        begin
            out_last_next        = 1'b1;
            out_data_next[33:22] = cnt;
            out_data_next[34]    = trunc;
            active_next          = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg <= FORMAT_MODE_RST;
            capacity_reg    <= BUFFER_CAPACITY_RST;
            phase_reg       <= PH_INT;
            count_reg       <= 12'd0;
            lone_zero_reg   <= 1'b0;
            active_reg      <= 1'b0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FORMAT_MODE:     format_mode_reg <= cfg_data[4:0];
                    CFG_BUFFER_CAPACITY: capacity_reg    <= cfg_data;
                    default:             capacity_reg    <= capacity_reg;
                endcase
            end
            if (take)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                lone_zero_reg <= lone_zero_next;
                active_reg    <= active_next;
                ovf_reg       <= ovf_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sim/numeric_literal_scanner_tb.sv =====
// Self-checking testbench for the numeric literal scanner.
module numeric_literal_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nls_pkg::*;

    // The run is stopped as a failure once this many clock cycles have passed.
    localparam int CYCLE_LIMIT = 300000;
    // Settling margin after the last result, spent before any register write.
    localparam int SETTLE_CYCLES = 6;
    localparam int TOKEN_LEN_LIMIT = MAX_TOKEN_LEN_DEF;
    localparam int PHASE_BEATS = 120;
    localparam int MAX_REPORTS = 20;
    localparam logic [12:0] LONG_TOKEN_CAP = 13'd100;
    localparam int LONG_TOKEN_DIGITS = 140;

    localparam logic [4:0] MODE_NONE = 5'd0;
    localparam logic [4:0] MODE_ALL = 5'h1F;

    // Scanner phases of the predictor; the gaps in the numbering are unused codes.
    typedef enum logic [2:0] {
        SCAN_INT   = 3'd0,
        SCAN_FRAC  = 3'd2,
        SCAN_ESIGN = 3'd4,
        SCAN_EDIG  = 3'd5,
        SCAN_HEX   = 3'd6,
        SCAN_BIN   = 3'd7
    } scan_phase_e;

    // Layout of m_tdata, most significant field first.
    typedef struct packed {
        logic [4:0]  pad;
        logic        trunc;
        logic [11:0] length;
        logic [7:0]  sbyte;
        logic [11:0] sidx;
        logic        sen;
        logic        acc;
    } scan_beat_t;

    // One result beat: the token_done flag on m_tlast plus the data word.
    typedef struct packed {
        logic       done;
        scan_beat_t data;
    } scan_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] in_byte
    logic [1:0]  s_tuser = 2'd0;     // [0] token_start, [1] end_of_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [0] accepted ... [34] truncated, [39:35] zero
    logic        m_tlast;            // token_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_FORMAT_MODE;
    logic [12:0] cfg_data = 13'd0;

    numeric_literal_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the configuration and of the scanner state.
    logic [4:0]  fmt_mode;
    logic [12:0] buf_cap;
    scan_phase_e phase;
    logic [11:0] char_count;
    logic        lone_zero;
    logic        token_open;
    logic        count_sat;

    // Results predicted for accepted input beats, oldest first.
    scan_result_t pending_results[$];
    logic [7:0]   literal_chars[$];

    // When set, neither side inserts idle cycles.
    logic steady = 1'b0;

    int error_count = 0;
    int cycle_count = 0;
    int scanned_beats = 0;
    int chars_taken = 0;
    int tokens_closed = 0;
    int truncations = 0;
    int settings_used = 0;

    scan_result_t got_beat;
    scan_result_t want_beat;
    int           stall_left = 0;

    // Characters that sit on the borders between the scanner phases.
    logic [7:0] tricky[10] = '{CH_ZERO, CH_ONE, CH_DOT, CH_LO_E, CH_UP_X,
                               CH_LO_H, CH_UP_B, CH_PLUS, CH_MINUS, CH_NINE};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a missing result or a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("numeric_literal_scanner_tb: done, errors");
            $finish;
        end
    end

    // Receiver: m_tready drops at random, with a chance of 6 in 100 each cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 6)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result checker. Signals are read right after the edge, so they still
    // hold the values that the edge sampled.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_beat.done = m_tlast;
            got_beat.data = m_tdata;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected: done=%b data=%h",
                             $realtime, m_tlast, m_tdata);
            end
            else
            begin
                want_beat = pending_results.pop_front();
                if (got_beat !== want_beat)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch, expected acc=%b en=%b idx=%0d byte=%h %s",
                                 $realtime, want_beat.data.acc, want_beat.data.sen,
                                 want_beat.data.sidx, want_beat.data.sbyte,
                                 $sformatf("done=%b len=%0d trunc=%b pad=%h",
                                           want_beat.done, want_beat.data.length,
                                           want_beat.data.trunc, want_beat.data.pad));
                        $display("%0t:           actual   acc=%b en=%b idx=%0d byte=%h %s",
                                 $realtime, got_beat.data.acc, got_beat.data.sen,
                                 got_beat.data.sidx, got_beat.data.sbyte,
                                 $sformatf("done=%b len=%0d trunc=%b pad=%h",
                                           got_beat.done, got_beat.data.length,
                                           got_beat.data.trunc, got_beat.data.pad));
                    end
                end
            end
        end
    end

    // Decides whether character c continues the literal in the current phase.
    // May move the phase forward, as the scanner does.
    function automatic logic char_fits(input logic [7:0] c);
        logic is_digit;
        logic is_sign;
        logic at_first;
        is_digit = c >= CH_ZERO && c <= CH_NINE;
        is_sign = c == CH_PLUS || c == CH_MINUS;
        at_first = char_count == 0 && !count_sat;
        // An exponent sign is optional: anything else is judged as a digit.
        if (phase == SCAN_ESIGN)
        begin
            phase = SCAN_EDIG;
            if (is_sign)
                return 1'b1;
        end
        case (phase)
            SCAN_HEX:
                return is_digit || (c >= CH_LO_A && c <= CH_LO_F)
                       || (c >= CH_UP_A && c <= CH_UP_F);
            SCAN_BIN:
                return c == CH_ZERO || c == CH_ONE;
            default:
                ;
        endcase
        if (is_digit)
        begin
            if (at_first)
                lone_zero = c == CH_ZERO;
            return 1'b1;
        end
        if (phase == SCAN_INT && c == CH_DOT && fmt_mode[FM_FLOAT])
        begin
            phase = SCAN_FRAC;
            return 1'b1;
        end
        if (phase != SCAN_EDIG && (c == CH_LO_E || c == CH_UP_E) && fmt_mode[FM_FLOAT])
        begin
            phase = SCAN_ESIGN;
            return 1'b1;
        end
        // A radix letter is only taken right after a lone leading zero.
        if (phase == SCAN_INT && lone_zero && char_count == 1 && !count_sat)
        begin
            if ((fmt_mode[FM_HEX_H] && (c == CH_LO_H || c == CH_UP_H))
                || (fmt_mode[FM_HEX_X] && (c == CH_LO_X || c == CH_UP_X)))
            begin
                phase = SCAN_HEX;
                return 1'b1;
            end
            if (fmt_mode[FM_BIN] && (c == CH_LO_B || c == CH_UP_B))
            begin
                phase = SCAN_BIN;
                return 1'b1;
            end
        end
        return fmt_mode[FM_SIGN] && at_first && is_sign;
    endfunction

    // Works out the result beat for one input beat and advances the state.
    function automatic scan_result_t predict_scan_result(input logic [7:0] c,
                                                         input logic start,
                                                         input logic eod);
        scan_result_t r;
        int cap;
        r = '0;
        cap = buf_cap;
        if (cap < 1)
            cap = 1;
        if (cap > TOKEN_LEN_LIMIT)
            cap = TOKEN_LEN_LIMIT;
        if (start)
        begin
            phase = SCAN_INT;
            char_count = '0;
            lone_zero = 1'b0;
            count_sat = 1'b0;
            token_open = 1'b1;
        end
        if (!token_open)
            return r;
        if (!eod && char_fits(c))
        begin
            r.data.acc = 1'b1;
            if (!count_sat && char_count < cap)
            begin
                r.data.sen = 1'b1;
                r.data.sidx = char_count;
                r.data.sbyte = c;
            end
            if (char_count < LEN_MAX)
                char_count++;
            else
                count_sat = 1'b1;
            chars_taken++;
            return r;
        end
        // Rejected byte or end of data: the token closes and the byte is dropped.
        r.done = 1'b1;
        r.data.length = char_count;
        r.data.trunc = count_sat || char_count >= cap;
        token_open = 1'b0;
        tokens_closed++;
        if (r.data.trunc)
            truncations++;
        return r;
    endfunction

    // Sends one input beat, at times after a random idle gap, and records
    // the expected result once the beat is taken. Valid stays high on return.
    task automatic feed_char(input logic [7:0] c, input logic start, input logic eod);
        if (!steady && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= {eod, start};
        do
            @(posedge clk);
        while (!s_tready);
        // Beats that arrive with no literal open are only ignored by the block.
        if (start || token_open)
            scanned_beats++;
        pending_results.push_back(predict_scan_result(c, start, eod));
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            feed_char(s[i], i == 0, 1'b0);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers back to back; only called while the block is idle.
    task automatic set_format(input logic [4:0] mode, input logic [12:0] cap);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FORMAT_MODE;
        cfg_data <= {8'd0, mode};
        do
            @(posedge clk);
        while (!cfg_ready);
        fmt_mode = mode;
        cfg_index <= CFG_BUFFER_CAPACITY;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        buf_cap = cap;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10)
            return 8'(CH_ZERO + k);
        if (k < 16)
            return 8'(CH_LO_A + k - 10);
        return 8'(CH_UP_A + k - 16);
    endfunction

    // Builds one literal in literal_chars. Most are well formed for some
    // format; a few are near misses or plain noise.
    task automatic build_literal();
        int kind;
        literal_chars.delete();
        if ($urandom_range(0, 3) == 0)
            literal_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2:
                repeat ($urandom_range(1, 8)) literal_chars.push_back(rand_digit());
            3, 4:
            begin
                repeat ($urandom_range(1, 4)) literal_chars.push_back(rand_digit());
                if ($urandom_range(0, 3) != 0)
                begin
                    literal_chars.push_back(CH_DOT);
                    repeat ($urandom_range(0, 4)) literal_chars.push_back(rand_digit());
                end
                if ($urandom_range(0, 1))
                begin
                    literal_chars.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
                    if ($urandom_range(0, 1))
                        literal_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    repeat ($urandom_range(0, 3)) literal_chars.push_back(rand_digit());
                end
            end
            5, 6:
            begin
                literal_chars.push_back(CH_ZERO);
                case ($urandom_range(0, 3))
                    0: literal_chars.push_back(CH_LO_X);
                    1: literal_chars.push_back(CH_UP_X);
                    2: literal_chars.push_back(CH_LO_H);
                    default: literal_chars.push_back(CH_UP_H);
                endcase
                repeat ($urandom_range(1, 6)) literal_chars.push_back(rand_hex_char());
            end
            7:
            begin
                literal_chars.push_back(CH_ZERO);
                literal_chars.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
                repeat ($urandom_range(1, 10))
                    literal_chars.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
            end
            8:
                repeat ($urandom_range(1, 5))
                    literal_chars.push_back(tricky[$urandom_range(0, 9)]);
            default:
                repeat ($urandom_range(1, 5))
                    literal_chars.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Feeds random literals until the given number of scanner beats has gone in.
    task automatic run_literals(input int goal);
        int target;
        int pick;
        target = scanned_beats + goal;
        while (scanned_beats < target)
        begin
            // Stray bytes between tokens are mostly ignored.
            if ($urandom_range(0, 9) == 0)
                feed_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            build_literal();
            foreach (literal_chars[i])
                feed_char(literal_chars[i], i == 0, 1'b0);
            pick = $urandom_range(0, 9);
            if (pick < 2)
                feed_char(tricky[$urandom_range(0, 9)], 1'b0, 1'b0);
            else if (pick < 4)
                feed_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else if (pick < 7)
                feed_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            else if (pick < 8)
                feed_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            // Otherwise the next literal's start drops this one unreported.
        end
    endtask

    // Reset settings: float only, capacity 64. Ignored beats while idle, a
    // full float with a signed exponent closed by byte 0xFF, an empty token,
    // and a hex prefix that float-only mode rejects.
    task automatic test_float_defaults();
        feed_char(8'h00, 1'b0, 1'b0);
        feed_char(8'hFF, 1'b0, 1'b1);
        feed_text("1.5e+9");
        feed_char(8'hFF, 1'b0, 1'b0);
        feed_char(8'h00, 1'b1, 1'b1);
        feed_text("0x");
        wait_idle();
    endtask

    // Every format enabled and capacity 0, which acts as 1, so every closed
    // token is truncated. A sign ahead of a hex prefix stops the token at the
    // x, since the prefix needs a lone leading zero; a binary token ends on
    // end of data, and a 0h token ends on a bad digit.
    task automatic test_prefixes();
        set_format(MODE_ALL, 13'd0);
        feed_text("-0x1F");
        feed_text("0b1");
        feed_char(8'h00, 1'b0, 1'b1);
        feed_text("0hA");
        feed_char("g", 1'b0, 1'b0);
        wait_idle();
    endtask

    // A token longer than the buffer: storing stops at the capacity while
    // the length keeps counting, and truncation is reported.
    task automatic test_long_token();
        set_format(MODE_ALL, LONG_TOKEN_CAP);
        feed_char(CH_NINE, 1'b1, 1'b0);
        repeat (LONG_TOKEN_DIGITS) feed_char(rand_digit(), 1'b0, 1'b0);
        feed_char(CH_MINUS, 1'b0, 1'b0);
        wait_idle();
    endtask

    // Random literals over a series of settings, among them every format
    // bit off, every bit on, capacities of 0 or 1 and, at random, 8191.
    task automatic test_random_settings();
        logic [4:0]  mode;
        logic [12:0] cap;
        for (int i = 0; i < 11; i++)
        begin
            mode = (i == 0) ? MODE_ALL : (i == 1) ? MODE_NONE : 5'($urandom_range(0, 31));
            case (i % 5)
                0: cap = 13'($urandom_range(1, 12));
                1: cap = 13'($urandom_range(0, 1));
                2: cap = 13'($urandom_range(2, 40));
                3: cap = 13'(TOKEN_LEN_LIMIT);
                default: cap = $urandom_range(0, 1) ? 13'h1FFF : 13'($urandom_range(0, 8191));
            endcase
            set_format(mode, cap);
            run_literals(PHASE_BEATS);
            wait_idle();
        end
    endtask

    // Back-to-back beats with the receiver always ready.
    task automatic test_steady_stream();
        set_format(MODE_ALL, 13'd8);
        steady = 1'b1;
        run_literals(PHASE_BEATS);
        wait_idle();
        steady = 1'b0;
    endtask

    initial
    begin
        fmt_mode = FORMAT_MODE_RST;
        buf_cap = BUFFER_CAPACITY_RST;
        phase = SCAN_INT;
        char_count = '0;
        lone_zero = 1'b0;
        token_open = 1'b0;
        count_sat = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_float_defaults();
        test_prefixes();
        test_long_token();
        test_random_settings();
        test_steady_stream();
        wait_idle();

        $display("Scanned %0d beats over %0d register settings plus the reset one.",
                 scanned_beats, settings_used);
        $display("%0d characters taken, %0d tokens closed, %0d of them truncated; %0d errors.",
                 chars_taken, tokens_closed, truncations, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("numeric_literal_scanner_tb: done, clean");
        else
            $display("numeric_literal_scanner_tb: done, errors");
        $finish;
    end

endmodule

// ===== numeric_literal_scanner.f =====
design/nls_pkg.sv
design/nls_front.sv
design/nls_fifo.sv
design/nls_back.sv
design/numeric_literal_scanner.sv
sim/numeric_literal_scanner_tb.sv
